// ===== rtl/tdp_pkg.sv =====
package tdp_pkg;

  // Widths of the beat fields and of one table entry.
  localparam int VALUE_W = 24;
  localparam int ENTRY_W = 12;
  localparam int MODE_W  = 2;
  localparam int SQ_W    = 2 * ENTRY_W;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Sequencer states of the test walk.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_CMP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== rtl/trial_division_prime_test.sv =====
// Load and clear beats are handled in the idle state and give no result.
// A test beat walks the table. Each entry walked passes through a table read, a squaring
// multiply, a compare, then one remainder bit per cycle in the bit-serial unit.
// A new beat is taken once the result moves to the output register, even while it still waits there.
// Synchronous active-low reset empties the table count; table contents stay undefined.
module trial_division_prime_test #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tdp_pkg::MODE_W-1:0]   in_mode,
  input  logic [tdp_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tdp_pkg::VALUE_W-1:0]  out_candidate,
  output logic                         out_is_prime
);
  import tdp_pkg::*;

  localparam int CAND_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BIT_W  = $clog2(CAND_W);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CAND_W-1:0]  n_r, n_nxt;
  logic [ENTRY_W-1:0] div_r, div_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [ENTRY_W-1:0] rem_r, rem_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_cand_r, out_cand_nxt;
  logic               out_prime_r, out_prime_nxt;

  logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [CAND_W-1:0]  in_v;
  logic [VALUE_W-1:0] in_v_full;
  logic               in_beat;
  logic [ENTRY_W:0]   trial;
  logic [ENTRY_W:0]   diff;

  assign in_ready      = (state_r == S_IDLE);
  assign in_beat       = in_valid && in_ready;
  assign in_v          = in_value[CAND_W-1:0];
  assign in_v_full     = VALUE_W'(in_v);
  assign wr_data       = in_v_full[ENTRY_W-1:0];
  assign out_valid     = out_valid_r;
  assign out_candidate = out_cand_r;
  assign out_is_prime  = out_prime_r;

  // One restoring step of the bit-serial remainder unit.
  assign trial = {rem_r, n_r[bit_r]};
  assign diff  = trial - {1'b0, div_r};

  // Table memory: one write port for loads, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= table_mem[idx_r[IDX_W-1:0]];
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    n_r         <= n_nxt;
    div_r       <= div_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    res_r       <= res_nxt;
    out_cand_r  <= out_cand_nxt;
    out_prime_r <= out_prime_nxt;
  end

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_cand_nxt  = out_cand_r;
    out_prime_nxt = out_prime_r;
    wr_en         = 1'b0;

    // The result register empties when the downstream side takes its beat.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          case (in_mode)
            MODE_LOAD: begin
              if (count_r < CNT_W'(TABLE_DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
            end
            MODE_TEST: begin
              n_nxt   = in_v;
              idx_nxt = '0;
              if (in_v < CAND_W'(2)) begin
                res_nxt   = 1'b0;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        // The end of the table means no divisor was found.
        if (idx_r == count_r) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        div_nxt   = rd_data_r;
        sq_nxt    = SQ_W'(rd_data_r) * SQ_W'(rd_data_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (div_r == '0) begin
          // A zero entry is skipped.
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_FETCH;
        end else if (sq_r > SQ_W'(n_r)) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rem_nxt   = '0;
          bit_nxt   = BIT_W'(CAND_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!diff[ENTRY_W]) begin
          rem_nxt = diff[ENTRY_W-1:0];
        end else begin
          rem_nxt = trial[ENTRY_W-1:0];
        end
        if (bit_r == '0) begin
          if (rem_nxt == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_FETCH;
          end
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cand_nxt  = VALUE_W'(n_r);
          out_prime_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("table count exceeds depth");

  // The walk index stays within the filled part of the table.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH || state_r == S_MUL || state_r == S_CMP || state_r == S_DIV)
    |-> idx_r < count_r || (state_r == S_FETCH && idx_r == count_r))
    else $error("walk index beyond table count");

  // The remainder unit only runs with a nonzero divisor and a reduced remainder.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_r != '0 && rem_r < div_r))
    else $error("remainder unit out of range");

  // A clear beat empties the table.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == MODE_CLEAR) |=> count_r == '0)
    else $error("clear did not empty the table");
`endif

endmodule
